FILE: rtl/dqr_pkg.sv
// ----------------------------------------------------------------------------
// dqr_pkg: shared types and constants for the position deque
// Command and status codes, widths and the operation record that goes from
// the command front end to the store back end.
// ----------------------------------------------------------------------------
package dqr_pkg;

  localparam int unsigned StoreDepth = 256;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned CountW     = AddrW + 1;
  localparam int unsigned CoordW     = 8;
  localparam int unsigned SymW       = 8;
  localparam int unsigned EntryW     = 2 * CoordW + SymW;
  localparam int unsigned InDataW    = 40;
  localparam int unsigned OutDataW   = 40;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CountW-1:0] CapReset = CountW'(200);
  localparam logic [CountW-1:0] CapMax   = CountW'(StoreDepth);

  typedef enum logic [2:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_REM_HEAD = 3'd2,
    CMD_REM_TAIL = 3'd3,
    CMD_RD_HEAD  = 3'd4,
    CMD_RD_TAIL  = 3'd5,
    CMD_RD_INDEX = 3'd6,
    CMD_REVERSE  = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic [SymW-1:0]   sym;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } entry_t;

  // One store operation with the result fields already known
  typedef struct packed {
    logic              wr;
    logic              rd;
    logic [AddrW-1:0]  addr;
    entry_t            entry;
    status_e           status;
    logic [CountW-1:0] count;
  } op_t;

endpackage

FILE: rtl/dqr_front.sv
// ----------------------------------------------------------------------------
// dqr_front: command front end
// Holds head pointer, count, direction flag and capacity; decodes each
// command, updates the list state and issues one store operation.
// ----------------------------------------------------------------------------
module dqr_front import dqr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CountW-1:0]   cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic [InDataW-1:0]  in_data_i,
  output logic                in_ready_o,
  input  logic                q_full_i,
  output logic                push_o,
  output op_t                 op_o
);

  logic [AddrW-1:0]  head_q, head_d;
  logic [CountW-1:0] count_q, count_d;
  logic              rev_q, rev_d;
  logic [CountW-1:0] cap_q;
  logic [CountW-1:0] cap_eff;
  cmd_e              cmd;
  entry_t            ent;
  logic [AddrW-1:0]  pos;
  logic [AddrW-1:0]  cnt_lo, cnt_m1;
  logic              empty, full;

  // Ring slot of a list position
  function automatic logic [AddrW-1:0] slot_of(logic [AddrW-1:0] head, logic rev,
                                               logic [AddrW-1:0] p);
    slot_of = rev ? head - p : head + p;
  endfunction

  assign in_ready_o = ~q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

  // Field unpacking
  assign cmd       = cmd_e'(in_data_i[2:0]);
  assign ent.x     = in_data_i[10:3];
  assign ent.y     = in_data_i[18:11];
  assign ent.sym   = in_data_i[26:19];
  assign pos       = in_data_i[34:27];

  assign cap_eff = (cap_q > CapMax) ? CapMax : cap_q;
  assign cnt_lo  = count_q[AddrW-1:0];
  assign cnt_m1  = cnt_lo - AddrW'(1);
  assign empty   = (count_q == '0);
  assign full    = (count_q >= cap_eff);

  // Command decode and next list state
  always_comb begin
    head_d       = head_q;
    count_d      = count_q;
    rev_d        = rev_q;
    op_o.wr      = 1'b0;
    op_o.rd      = 1'b0;
    op_o.addr    = '0;
    op_o.entry   = ent;
    op_o.status  = ST_OK;
    unique case (cmd)
      CMD_INS_HEAD: begin
        if (full) begin
          op_o.status = ST_FULL;
        end else begin
          head_d    = rev_q ? head_q + AddrW'(1) : head_q - AddrW'(1);
          op_o.wr   = 1'b1;
          op_o.addr = head_d;
          count_d   = count_q + CountW'(1);
        end
      end
      CMD_INS_TAIL: begin
        if (full) begin
          op_o.status = ST_FULL;
        end else begin
          op_o.wr   = 1'b1;
          op_o.addr = slot_of(head_q, rev_q, cnt_lo);
          count_d   = count_q + CountW'(1);
        end
      end
      CMD_REM_HEAD: begin
        if (empty) begin
          op_o.status = ST_EMPTY;
        end else begin
          head_d  = slot_of(head_q, rev_q, AddrW'(1));
          count_d = count_q - CountW'(1);
        end
      end
      CMD_REM_TAIL: begin
        if (empty) begin
          op_o.status = ST_EMPTY;
        end else begin
          count_d = count_q - CountW'(1);
        end
      end
      CMD_RD_HEAD: begin
        if (empty) begin
          op_o.status = ST_EMPTY;
        end else begin
          op_o.rd   = 1'b1;
          op_o.addr = head_q;
        end
      end
      CMD_RD_TAIL: begin
        if (empty) begin
          op_o.status = ST_EMPTY;
        end else begin
          op_o.rd   = 1'b1;
          op_o.addr = slot_of(head_q, rev_q, cnt_m1);
        end
      end
      CMD_RD_INDEX: begin
        if (empty) begin
          op_o.status = ST_EMPTY;
        end else if ({1'b0, pos} >= count_q) begin
          op_o.status = ST_RANGE;
        end else begin
          op_o.rd   = 1'b1;
          op_o.addr = slot_of(head_q, rev_q, pos);
        end
      end
      CMD_REVERSE: begin
        if (!empty) begin
          head_d = slot_of(head_q, rev_q, cnt_m1);
        end
        rev_d = ~rev_q;
      end
      default: ;
    endcase
    op_o.count = count_d;
  end

  // List state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      rev_q   <= 1'b0;
    end else if (push_o) begin
      head_q  <= head_d;
      count_q <= count_d;
      rev_q   <= rev_d;
    end
  end

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

endmodule

FILE: rtl/dqr_queue.sv
// ----------------------------------------------------------------------------
// dqr_queue: operation queue
// Short first-in first-out buffer of store operations between the front
// end and the back end.
// ----------------------------------------------------------------------------
module dqr_queue import dqr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_op_i,
  output logic full_o,
  input  logic pop_i,
  output logic not_empty_o,
  output op_t  pop_op_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  op_t                 slots_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]       fill_q;
  logic                do_push, do_pop;

  assign full_o      = (fill_q == (PtrW+1)'(QueueDepth));
  assign not_empty_o = (fill_q != '0);
  assign pop_op_o    = slots_q[rd_ptr_q];
  assign do_push     = push_i & ~full_o;
  assign do_pop      = pop_i & not_empty_o;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_op_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (do_push && !do_pop) begin
        fill_q <= fill_q + (PtrW+1)'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - (PtrW+1)'(1);
      end
    end
  end

endmodule

FILE: rtl/dqr_back.sv
// ----------------------------------------------------------------------------
// dqr_back: store back end
// Carries out each queued operation on the ring store and holds the result
// in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module dqr_back import dqr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_not_empty_i,
  input  op_t                  q_op_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OutDataW-1:0]  out_data_o
);

  entry_t            store_q [StoreDepth];
  entry_t            rd_data_q;
  logic              out_valid_q;
  logic              rd_q;
  status_e           status_q;
  logic [CountW-1:0] count_q;
  entry_t            shown;

  // Take the next operation whenever the output register is free
  assign pop_o = q_not_empty_i & (~out_valid_q | out_ready_i);

  // Ring store: one access per operation
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      if (q_op_i.wr) begin
        store_q[q_op_i.addr] <= q_op_i.entry;
      end
      rd_data_q <= store_q[q_op_i.addr];
    end
  end

  // Result fields
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_q     <= q_op_i.rd;
      status_q <= q_op_i.status;
      count_q  <= q_op_i.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Entry fields read as zero when nothing was read
  assign shown       = rd_q ? rd_data_q : '0;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = {4'b0, count_q, status_q, rd_q, shown.sym, shown.y, shown.x};

endmodule

FILE: rtl/position_deque_with_reverse.sv
// ----------------------------------------------------------------------------
// position_deque_with_reverse: double-ended list of position entries
// Insert, remove and read at either end, indexed read and order reversal
// over a ring store, with one result per command.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_axis channel, one result per command leaves on
//   the m_axis channel. cfg_we_i with cfg_wdata_i sets the capacity; write
//   it only while no command is in flight.
//   The operation is written into the queue at the transfer, then popped
//   into the output register. One command per cycle while results are taken,
//   set by the single store port; every command is one store access.
//   The front end updates head, count and direction at the transfer; a
//   two-entry queue feeds the back end, which owns the store.
//   Receiver stall: the result stays in the output register, the queue
//   fills, and s_axis_tready drops once it is full.
//   Reset: empty list, forward order, capacity 200. Store contents are not
//   cleared; only written slots ever reach the output.
// ----------------------------------------------------------------------------
module position_deque_with_reverse import dqr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Capacity register
  input  logic                cfg_we_i,
  input  logic [CountW-1:0]   cfg_wdata_i,
  // Commands
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // command[2:0], entry_x[10:3], entry_y[18:11], entry_symbol[26:19],
  // position[34:27], zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  // Results
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // out_x[7:0], out_y[15:8], out_symbol[23:16], read_valid[24],
  // status[26:25], entry_count[35:27], zero fill
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic push, q_full, pop, q_not_empty;
  op_t  push_op, pop_op;

  dqr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_data_i   (s_axis_tdata),
    .in_ready_o  (s_axis_tready),
    .q_full_i    (q_full),
    .push_o      (push),
    .op_o        (push_op)
  );

  dqr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_op_i   (push_op),
    .full_o      (q_full),
    .pop_i       (pop),
    .not_empty_o (q_not_empty),
    .pop_op_o    (pop_op)
  );

  dqr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_not_empty_i (q_not_empty),
    .q_op_i        (pop_op),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (m_axis_tdata)
  );

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for position_deque_with_reverse
// Streams commands into the deque with random gaps and result back-pressure.
// A local copy of the list state (ring, head, direction, count, capacity)
// predicts every result, and each output transfer is checked field by field.
// The capacity is rewritten between phases only while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import dqr_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned MaxReported   = 10;

  // Expected result of one command
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [SymW-1:0]   sym;
    logic              rd_valid;
    status_e           status;
    logic [CountW-1:0] count;
  } deque_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CountW-1:0]   cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  // Stimulus and expectations
  logic [InDataW-1:0] pending_cmds[$];
  deque_result_t      expected_results[$];

  // Local copy of the list state
  entry_t            ring_copy [StoreDepth];
  logic [AddrW-1:0]  head_copy     = '0;
  logic [CountW-1:0] count_copy    = '0;
  logic              reversed_copy = 1'b0;
  logic [CountW-1:0] capacity_copy = CapReset;

  // Handshake and pacing state
  bit cmd_taken        = 1'b0;
  bit send_gaps_on     = 1'b1;
  bit accept_stalls_on = 1'b1;
  int send_gap         = 0;
  int stall_left       = 0;
  int idle_cycles      = 0;

  // Tallies
  int mismatches   = 0;
  int results_seen = 0;
  int reads_done   = 0;
  int peak_count   = 0;
  int cmd_tally [8];
  int status_tally [4];

  position_deque_with_reverse uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int draw_gap(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // command[2:0], x[10:3], y[18:11], symbol[26:19], position[34:27]
  function automatic logic [InDataW-1:0] pack_command(cmd_e op, int x, int y, int sym, int pos);
    logic [InDataW-1:0] word;
    word        = '0;
    word[2:0]   = op;
    word[10:3]  = x[7:0];
    word[18:11] = y[7:0];
    word[26:19] = sym[7:0];
    word[34:27] = pos[7:0];
    return word;
  endfunction

  function automatic logic [InDataW-1:0] random_command(int ins_pct, int rem_pct);
    int   r;
    cmd_e op;
    int   pos;
    r = $urandom_range(0, 99);
    if (r < ins_pct) begin
      op = $urandom_range(0, 1) ? CMD_INS_TAIL : CMD_INS_HEAD;
    end else if (r < ins_pct + rem_pct) begin
      op = $urandom_range(0, 1) ? CMD_REM_TAIL : CMD_REM_HEAD;
    end else begin
      op = cmd_e'(3'($urandom_range(4, 7)));
    end
    pos = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 255);
    return pack_command(op, $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255), pos);
  endfunction

  // Ring slot of a list position under the current head and direction
  function automatic logic [AddrW-1:0] slot_at(logic [AddrW-1:0] pos);
    logic [AddrW-1:0] slot;
    slot = reversed_copy ? head_copy - pos : head_copy + pos;
    return slot;
  endfunction

  // Apply one command to the local list copy and return its result
  function automatic deque_result_t apply_command(logic [InDataW-1:0] word);
    cmd_e              op;
    entry_t            ent;
    logic [AddrW-1:0]  pos;
    logic [AddrW-1:0]  rd_pos;
    logic [CountW-1:0] cap;
    logic              do_read;
    deque_result_t     res;
    op      = cmd_e'(word[2:0]);
    ent.x   = word[10:3];
    ent.y   = word[18:11];
    ent.sym = word[26:19];
    pos     = word[34:27];
    cap     = (capacity_copy > CapMax) ? CapMax : capacity_copy;
    do_read = 1'b0;
    rd_pos  = '0;
    res     = '0;
    res.status = ST_OK;
    case (op)
      CMD_INS_HEAD, CMD_INS_TAIL: begin
        if (count_copy >= cap) begin
          res.status = ST_FULL;
        end else if (op == CMD_INS_HEAD) begin
          head_copy = reversed_copy ? head_copy + AddrW'(1) : head_copy - AddrW'(1);
          ring_copy[head_copy] = ent;
          count_copy++;
        end else begin
          ring_copy[slot_at(count_copy[AddrW-1:0])] = ent;
          count_copy++;
        end
      end
      CMD_REM_HEAD, CMD_REM_TAIL: begin
        if (count_copy == '0) begin
          res.status = ST_EMPTY;
        end else begin
          if (op == CMD_REM_HEAD) head_copy = slot_at(AddrW'(1));
          count_copy--;
        end
      end
      CMD_RD_HEAD, CMD_RD_TAIL, CMD_RD_INDEX: begin
        if (count_copy == '0) begin
          res.status = ST_EMPTY;
        end else if (op == CMD_RD_INDEX && CountW'(pos) >= count_copy) begin
          res.status = ST_RANGE;
        end else begin
          do_read = 1'b1;
          case (op)
            CMD_RD_HEAD: rd_pos = '0;
            CMD_RD_TAIL: rd_pos = AddrW'(count_copy - CountW'(1));
            default:     rd_pos = pos;
          endcase
        end
      end
      default: begin
        // reverse: the tail becomes the head, an empty list only flips
        if (count_copy != '0) head_copy = slot_at(AddrW'(count_copy - CountW'(1)));
        reversed_copy = ~reversed_copy;
      end
    endcase
    if (do_read) begin
      ent          = ring_copy[slot_at(rd_pos)];
      res.x        = ent.x;
      res.y        = ent.y;
      res.sym      = ent.sym;
      res.rd_valid = 1'b1;
    end
    res.count = count_copy;
    return res;
  endfunction

  task automatic note_failure(string msg);
    mismatches++;
    if (mismatches <= MaxReported) $display("ERROR: %s", msg);
  endtask

  // Compare one result transfer with the oldest expectation
  task automatic check_result(logic [OutDataW-1:0] word);
    deque_result_t got;
    deque_result_t want;
    got.x        = word[7:0];
    got.y        = word[15:8];
    got.sym      = word[23:16];
    got.rd_valid = word[24];
    got.status   = status_e'(word[26:25]);
    got.count    = word[35:27];
    if (expected_results.size() == 0) begin
      note_failure($sformatf("result %0d arrived with nothing expected (data 'h%0h)",
                             results_seen, word));
    end else begin
      want = expected_results.pop_front();
      if (got.x !== want.x)
        note_failure($sformatf("result %0d out_x: expected 'h%0h, got 'h%0h",
                               results_seen, want.x, got.x));
      if (got.y !== want.y)
        note_failure($sformatf("result %0d out_y: expected 'h%0h, got 'h%0h",
                               results_seen, want.y, got.y));
      if (got.sym !== want.sym)
        note_failure($sformatf("result %0d out_symbol: expected 'h%0h, got 'h%0h",
                               results_seen, want.sym, got.sym));
      if (got.rd_valid !== want.rd_valid)
        note_failure($sformatf("result %0d read_valid: expected %0b, got %0b",
                               results_seen, want.rd_valid, got.rd_valid));
      if (got.status !== want.status)
        note_failure($sformatf("result %0d status: expected %0d, got %0d",
                               results_seen, want.status, got.status));
      if (got.count !== want.count)
        note_failure($sformatf("result %0d entry_count: expected %0d, got %0d",
                               results_seen, want.count, got.count));
      status_tally[want.status]++;
      if (want.rd_valid) reads_done++;
    end
    results_seen++;
  endtask

  // Rising edge: model update, result check, watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) capacity_copy = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        cmd_tally[s_axis_tdata[2:0]]++;
        expected_results.push_back(apply_command(s_axis_tdata));
        if (int'(count_copy) > peak_count) peak_count = int'(count_copy);
        cmd_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("ERROR: no transfer for %0d cycles", idle_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Command driver: next item after the current transfer, with random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || cmd_taken) begin
      cmd_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        s_axis_tdata  <= pending_cmds.pop_front();
        s_axis_tvalid <= 1'b1;
        send_gap = draw_gap(send_gaps_on);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = draw_gap(accept_stalls_on);
    end
  end

  // Sender holds until every expected result has come back
  task automatic wait_idle();
    @(posedge clk_i);
    #1;
    while (pending_cmds.size() != 0 || s_axis_tvalid || expected_results.size() != 0) begin
      @(posedge clk_i);
      #1;
    end
    // let the two-stage pipeline settle
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_capacity(int value);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CountW'(value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic queue_cmd(cmd_e op, int x, int y, int sym, int pos);
    pending_cmds.push_back(pack_command(op, x, y, sym, pos));
  endtask

  task automatic run_phase(int cap, int n, int ins_pct, int rem_pct, bit paced);
    int i;
    write_capacity(cap);
    send_gaps_on     = paced;
    accept_stalls_on = paced;
    for (i = 0; i < n; i++) pending_cmds.push_back(random_command(ins_pct, rem_pct));
  endtask

  // Stimulus
  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty list at reset capacity: every remove, read and reverse on nothing
    queue_cmd(CMD_REM_HEAD, 0, 0, 0, 0);
    queue_cmd(CMD_REM_TAIL, 0, 0, 0, 0);
    queue_cmd(CMD_RD_HEAD, 0, 0, 0, 0);
    queue_cmd(CMD_RD_TAIL, 0, 0, 0, 0);
    queue_cmd(CMD_RD_INDEX, 0, 0, 0, 0);
    queue_cmd(CMD_REVERSE, 0, 0, 0, 0);
    // Inserts at both ends with extreme coordinates, order now reversed
    queue_cmd(CMD_INS_TAIL, 127, -128, 255, 255);
    queue_cmd(CMD_INS_HEAD, -128, 127, 0, 0);
    queue_cmd(CMD_INS_TAIL, 85, -86, 170, 170);
    queue_cmd(CMD_INS_HEAD, -1, -1, 85, 85);
    // Reads, out of range positions, reverse with entries
    queue_cmd(CMD_RD_HEAD, 0, 0, 0, 0);
    queue_cmd(CMD_RD_TAIL, 0, 0, 0, 0);
    queue_cmd(CMD_RD_INDEX, 0, 0, 0, 2);
    queue_cmd(CMD_RD_INDEX, 0, 0, 0, 3);
    queue_cmd(CMD_RD_INDEX, 0, 0, 0, 4);
    queue_cmd(CMD_RD_INDEX, 0, 0, 0, 255);
    queue_cmd(CMD_REVERSE, 0, 0, 0, 0);
    queue_cmd(CMD_RD_HEAD, 0, 0, 0, 0);
    queue_cmd(CMD_RD_INDEX, 0, 0, 0, 1);
    queue_cmd(CMD_REM_HEAD, 0, 0, 0, 0);
    queue_cmd(CMD_REM_TAIL, 0, 0, 0, 0);
    queue_cmd(CMD_RD_TAIL, 0, 0, 0, 0);
    queue_cmd(CMD_REM_HEAD, 0, 0, 0, 0);
    queue_cmd(CMD_REM_HEAD, 0, 0, 0, 0);
    queue_cmd(CMD_REM_TAIL, 0, 0, 0, 0);

    // Capacity of two: fill up, then an insert on a full list
    write_capacity(2);
    queue_cmd(CMD_INS_HEAD, 12, -12, 1, 0);
    queue_cmd(CMD_INS_TAIL, -34, 34, 2, 0);
    queue_cmd(CMD_INS_TAIL, 56, 56, 3, 0);
    queue_cmd(CMD_RD_TAIL, 0, 0, 0, 0);

    // Capacity lowered below the count: entries kept, inserts refused until the count drops below it
    write_capacity(1);
    queue_cmd(CMD_INS_HEAD, 7, 7, 7, 0);
    queue_cmd(CMD_REM_TAIL, 0, 0, 0, 0);
    queue_cmd(CMD_INS_TAIL, 8, 8, 8, 0);
    queue_cmd(CMD_REM_HEAD, 0, 0, 0, 0);
    queue_cmd(CMD_INS_TAIL, -99, 99, 200, 0);
    queue_cmd(CMD_RD_HEAD, 0, 0, 0, 0);

    // Capacity zero: always full
    write_capacity(0);
    queue_cmd(CMD_INS_HEAD, 1, 1, 1, 0);
    queue_cmd(CMD_INS_TAIL, 2, 2, 2, 0);
    queue_cmd(CMD_RD_INDEX, 0, 0, 0, 0);
    queue_cmd(CMD_REVERSE, 0, 0, 0, 0);
    queue_cmd(CMD_REM_HEAD, 0, 0, 0, 0);

    // Random phases: fill with the capacity at the store depth and drain, then mixed loads
    run_phase(256, 320, 75, 5, 1'b1);
    run_phase(256, 300, 10, 70, 1'b1);
    run_phase(1, 150, 40, 30, 1'b0);
    run_phase(5, 200, 45, 35, 1'b1);
    run_phase(384, 260, 55, 25, 1'b1);
    run_phase(37, 200, 45, 35, $urandom_range(0, 3) != 0);
    run_phase(200, 170, 40, 40, 1'b1);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (expected_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_results.size()));

    $display("Ran %0d commands: %0d/%0d inserts, %0d/%0d removes, %0d reads, %0d reversals",
             cmd_tally[CMD_INS_HEAD] + cmd_tally[CMD_INS_TAIL] + cmd_tally[CMD_REM_HEAD]
             + cmd_tally[CMD_REM_TAIL] + cmd_tally[CMD_RD_HEAD] + cmd_tally[CMD_RD_TAIL]
             + cmd_tally[CMD_RD_INDEX] + cmd_tally[CMD_REVERSE],
             cmd_tally[CMD_INS_HEAD], cmd_tally[CMD_INS_TAIL], cmd_tally[CMD_REM_HEAD],
             cmd_tally[CMD_REM_TAIL],
             cmd_tally[CMD_RD_HEAD] + cmd_tally[CMD_RD_TAIL] + cmd_tally[CMD_RD_INDEX],
             cmd_tally[CMD_REVERSE]);
    $display("Entries read %0d; ok %0d, full %0d, empty %0d, out of range %0d; peak count %0d",
             reads_done, status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_EMPTY],
             status_tally[ST_RANGE], peak_count);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/dqr_pkg.sv
rtl/dqr_front.sv
rtl/dqr_queue.sv
rtl/dqr_back.sv
rtl/position_deque_with_reverse.sv
test/tb.sv
